// ===== rtl/rpu_pkg.sv =====
// Shared types, codes and defaults of the raster pixel unpacker.
`default_nettype none
package rpu_pkg;

    localparam int MAP_ENTRIES_DEF = 256;
    localparam int CFG_INDEX_W     = 3;
    localparam int CFG_DATA_W      = 16;

    typedef enum logic [0:0] {
        CMD_MAP_WRITE = 1'b0,
        CMD_RASTER    = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        PLANE_RED   = 2'd0,
        PLANE_GREEN = 2'd1,
        PLANE_BLUE  = 2'd2
    } plane_t;

    // DEPTH_NONE is the unused code: raster bytes are dropped.
    typedef enum logic [1:0] {
        DEPTH_8    = 2'd0,
        DEPTH_24   = 2'd1,
        DEPTH_32   = 2'd2,
        DEPTH_NONE = 2'd3
    } depth_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_IMAGE_WIDTH   = 3'd0,
        CFG_IMAGE_HEIGHT  = 3'd1,
        CFG_DEPTH_MODE    = 3'd2,
        CFG_RED_FIRST     = 3'd3,
        CFG_USE_COLOR_MAP = 3'd4
    } cfg_index_t;

    // Live configuration seen by the decoder.
    typedef struct packed {
        logic [15:0] image_width;
        logic [15:0] image_height;
        logic [1:0]  depth_mode;
        logic        red_first;
    } cfg_t;

    // One decoded pixel before the color map lookup.
    typedef struct packed {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [15:0] column;
        logic [15:0] row;
        logic        last_pixel;
    } pix_t;

endpackage
`default_nettype wire

// ===== rtl/rpu_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module rpu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/rpu_decode.sv =====
// Byte-phase tracking, channel assembly and column/row counting.
`default_nettype none
module rpu_decode (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire rpu_pkg::cfg_t cfg,
    input  wire logic          beat,
    input  wire logic [7:0]    data_byte,
    output logic               pix_valid,
    output rpu_pkg::pix_t      pix
);

    logic [1:0]  byte_phase_reg,    byte_phase_next;
    logic [15:0] held_channels_reg, held_channels_next;
    logic [15:0] column_count_reg,  column_count_next;
    logic [15:0] line_count_reg,    line_count_next;
    logic        pad_pending_reg,   pad_pending_next;
    logic        image_done_reg,    image_done_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_phase_reg    <= '0;
            held_channels_reg <= '0;
            column_count_reg  <= '0;
            line_count_reg    <= '0;
            pad_pending_reg   <= 1'b0;
            image_done_reg    <= 1'b0;
        end else begin
            byte_phase_reg    <= byte_phase_next;
            held_channels_reg <= held_channels_next;
            column_count_reg  <= column_count_next;
            line_count_reg    <= line_count_next;
            pad_pending_reg   <= pad_pending_next;
            image_done_reg    <= image_done_next;
        end
    end

    always_comb begin
        logic [1:0]  last_phase;
        logic [15:0] col_inc;
        logic [15:0] line_inc;
        logic [7:0]  c0;
        logic [7:0]  c1;

        byte_phase_next    = byte_phase_reg;
        held_channels_next = held_channels_reg;
        column_count_next  = column_count_reg;
        line_count_next    = line_count_reg;
        pad_pending_next   = pad_pending_reg;
        image_done_next    = image_done_reg;
        pix_valid          = 1'b0;

        case (cfg.depth_mode)
            rpu_pkg::DEPTH_8:  last_phase = 2'd0;
            rpu_pkg::DEPTH_24: last_phase = 2'd2;
            default:           last_phase = 2'd3;
        endcase

        col_inc  = column_count_reg + 16'd1;
        line_inc = line_count_reg + 16'd1;
        c0       = held_channels_reg[7:0];
        c1       = held_channels_reg[15:8];

        // Channel assembly
        if (cfg.depth_mode == rpu_pkg::DEPTH_8) begin
            pix.red   = data_byte;
            pix.green = data_byte;
            pix.blue  = data_byte;
        end else if (cfg.red_first) begin
            pix.red   = c0;
            pix.green = c1;
            pix.blue  = data_byte;
        end else begin
            pix.blue  = c0;
            pix.green = c1;
            pix.red   = data_byte;
        end
        pix.column     = column_count_reg;
        pix.row        = cfg.image_height - 16'd1 - line_count_reg;
        pix.last_pixel = 1'b0;

        if (beat && !image_done_reg && cfg.depth_mode != rpu_pkg::DEPTH_NONE) begin
            if (pad_pending_reg) begin
                // drop the line pad byte
                pad_pending_next = 1'b0;
            end else if (byte_phase_reg < last_phase) begin
                if (cfg.depth_mode == rpu_pkg::DEPTH_32 && byte_phase_reg == 2'd0) begin
                    // drop the leading pad byte
                end else if ((cfg.depth_mode == rpu_pkg::DEPTH_24 && byte_phase_reg == 2'd0) ||
                             (cfg.depth_mode == rpu_pkg::DEPTH_32 && byte_phase_reg == 2'd1)) begin
                    held_channels_next = {held_channels_reg[15:8], data_byte};
                end else begin
                    held_channels_next = {data_byte, held_channels_reg[7:0]};
                end
                byte_phase_next = byte_phase_reg + 2'd1;
            end else begin
                byte_phase_next   = 2'd0;
                pix_valid         = 1'b1;
                column_count_next = col_inc;
                if (col_inc == cfg.image_width) begin
                    column_count_next = '0;
                    if (cfg.depth_mode != rpu_pkg::DEPTH_32 && cfg.image_width[0]) begin
                        pad_pending_next = 1'b1;
                    end
                    line_count_next = line_inc;
                    if (line_inc == cfg.image_height) begin
                        image_done_next  = 1'b1;
                        pad_pending_next = 1'b0;
                        pix.last_pixel   = 1'b1;
                    end
                end
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/raster_pixel_unpacker.sv =====
// Top level of the raster pixel unpacker: config, color map memories, output stage.
//
//  channel  | handshake          | payload
//  ---------+--------------------+--------------------------------------------------
//  s_       | s_valid / s_ready  | command, map_plane, map_index, data_byte
//  m_       | m_valid / m_ready  | red, green, blue, column, row, last_pixel
//  cfg_     | cfg_we             | cfg_index, cfg_wdata (no wait, no read-back)
//
// One beat per cycle is accepted while s_ready is high. After its last byte a pixel
// passes the registered color map read, then the output register. Reset (aresetn
// low at a clock edge) returns all counters and configuration to their defaults;
// map contents stay undefined until written. Output stalls back up through the
// lookup stage to s_ready; map writes need no forwarding because reads and writes
// both happen at beat acceptance.
`default_nettype none
module raster_pixel_unpacker #(
    parameter int MAP_ENTRIES = rpu_pkg::MAP_ENTRIES_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // configuration
    input  wire logic                           cfg_we,
    input  wire logic [rpu_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [rpu_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    // input beats
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic                           s_command,
    input  wire logic [1:0]                     s_map_plane,
    input  wire logic [7:0]                     s_map_index,
    input  wire logic [7:0]                     s_data_byte,
    // result beats
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic      [7:0]                     m_red,
    output logic      [7:0]                     m_green,
    output logic      [7:0]                     m_blue,
    output logic      [15:0]                    m_column,
    output logic      [15:0]                    m_row,
    output logic                                m_last_pixel
);

    localparam int AW = $clog2(MAP_ENTRIES);

    // ---------------- configuration registers ----------------
    rpu_pkg::cfg_t cfg_reg;
    logic          use_map_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.image_width  <= 16'd1;
            cfg_reg.image_height <= 16'd1;
            cfg_reg.depth_mode   <= rpu_pkg::DEPTH_8;
            cfg_reg.red_first    <= 1'b0;
            use_map_reg          <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_index)
                rpu_pkg::CFG_IMAGE_WIDTH:   cfg_reg.image_width  <= cfg_wdata;
                rpu_pkg::CFG_IMAGE_HEIGHT:  cfg_reg.image_height <= cfg_wdata;
                rpu_pkg::CFG_DEPTH_MODE:    cfg_reg.depth_mode   <= cfg_wdata[1:0];
                rpu_pkg::CFG_RED_FIRST:     cfg_reg.red_first    <= cfg_wdata[0];
                rpu_pkg::CFG_USE_COLOR_MAP: use_map_reg          <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // ---------------- handshake ----------------
    logic s1_valid_reg;
    logic m_valid_reg;
    logic out_free;
    logic s_fire;
    logic raster_beat;
    logic map_beat;

    assign out_free    = !m_valid_reg || m_ready;
    assign s_ready     = !s1_valid_reg || out_free;
    assign s_fire      = s_valid && s_ready;
    assign raster_beat = s_fire && (s_command == rpu_pkg::CMD_RASTER);
    assign map_beat    = s_fire && (s_command == rpu_pkg::CMD_MAP_WRITE);

    // ---------------- byte decoder ----------------
    logic          pix_valid;
    rpu_pkg::pix_t pix;

    rpu_decode u_decode (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .beat      (raster_beat),
        .data_byte (s_data_byte),
        .pix_valid (pix_valid),
        .pix       (pix)
    );

    // ---------------- color map planes ----------------
    // Writes beyond the map are dropped; lookups beyond it answer zero.
    logic          wr_in_range;
    logic [2:0]    rd_in_range;
    logic [2:0]    plane_we;
    logic [7:0]    rd_red, rd_green, rd_blue;

    assign wr_in_range    = {1'b0, s_map_index} < 9'(MAP_ENTRIES);
    assign rd_in_range[0] = {1'b0, pix.red}   < 9'(MAP_ENTRIES);
    assign rd_in_range[1] = {1'b0, pix.green} < 9'(MAP_ENTRIES);
    assign rd_in_range[2] = {1'b0, pix.blue}  < 9'(MAP_ENTRIES);

    assign plane_we[0] = map_beat && wr_in_range && (s_map_plane == rpu_pkg::PLANE_RED);
    assign plane_we[1] = map_beat && wr_in_range && (s_map_plane == rpu_pkg::PLANE_GREEN);
    assign plane_we[2] = map_beat && wr_in_range && (s_map_plane == rpu_pkg::PLANE_BLUE);

    rpu_ram #(.WIDTH(8), .DEPTH(MAP_ENTRIES)) u_map_red (
        .aclk  (aclk),
        .we    (plane_we[0]),
        .waddr (s_map_index[AW-1:0]),
        .wdata (s_data_byte),
        .re    (pix_valid),
        .raddr (pix.red[AW-1:0]),
        .rdata (rd_red)
    );

    rpu_ram #(.WIDTH(8), .DEPTH(MAP_ENTRIES)) u_map_green (
        .aclk  (aclk),
        .we    (plane_we[1]),
        .waddr (s_map_index[AW-1:0]),
        .wdata (s_data_byte),
        .re    (pix_valid),
        .raddr (pix.green[AW-1:0]),
        .rdata (rd_green)
    );

    rpu_ram #(.WIDTH(8), .DEPTH(MAP_ENTRIES)) u_map_blue (
        .aclk  (aclk),
        .we    (plane_we[2]),
        .waddr (s_map_index[AW-1:0]),
        .wdata (s_data_byte),
        .re    (pix_valid),
        .raddr (pix.blue[AW-1:0]),
        .rdata (rd_blue)
    );

    // ---------------- lookup stage ----------------
    // Hold the raw pixel while the map read completes; the RAM keeps its read
    // data because a new read only starts with the next pixel.
    rpu_pkg::pix_t s1_pix_reg;
    logic          s1_use_map_reg;
    logic [2:0]    s1_in_range_reg;
    logic          s1_move;

    assign s1_move = s1_valid_reg && out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (pix_valid) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_move) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pix_valid) begin
            s1_pix_reg      <= pix;
            s1_use_map_reg  <= use_map_reg;
            s1_in_range_reg <= rd_in_range;
        end
    end

    // ---------------- output register ----------------
    logic [7:0]  m_red_reg, m_green_reg, m_blue_reg;
    logic [15:0] m_column_reg, m_row_reg;
    logic        m_last_pixel_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_move) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_move) begin
            if (s1_use_map_reg) begin
                m_red_reg   <= s1_in_range_reg[0] ? rd_red   : 8'd0;
                m_green_reg <= s1_in_range_reg[1] ? rd_green : 8'd0;
                m_blue_reg  <= s1_in_range_reg[2] ? rd_blue  : 8'd0;
            end else begin
                m_red_reg   <= s1_pix_reg.red;
                m_green_reg <= s1_pix_reg.green;
                m_blue_reg  <= s1_pix_reg.blue;
            end
            m_column_reg     <= s1_pix_reg.column;
            m_row_reg        <= s1_pix_reg.row;
            m_last_pixel_reg <= s1_pix_reg.last_pixel;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_red        = m_red_reg;
    assign m_green      = m_green_reg;
    assign m_blue       = m_blue_reg;
    assign m_column     = m_column_reg;
    assign m_row        = m_row_reg;
    assign m_last_pixel = m_last_pixel_reg;

endmodule
`default_nettype wire

// ===== sim/unpacker_checker.sv =====
// Pixel predictor and result checker for the raster pixel unpacker.
`timescale 1ns / 100ps
module unpacker_checker (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [rpu_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [rpu_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                             s_valid,
    input  logic                             s_ready,
    input  logic                             s_command,
    input  logic [1:0]                       s_map_plane,
    input  logic [7:0]                       s_map_index,
    input  logic [7:0]                       s_data_byte,
    input  logic                             m_valid,
    input  logic                             m_ready,
    input  logic [7:0]                       m_red,
    input  logic [7:0]                       m_green,
    input  logic [7:0]                       m_blue,
    input  logic [15:0]                      m_column,
    input  logic [15:0]                      m_row,
    input  logic                             m_last_pixel,
    output int                               error_count,
    output int                               pending,
    output int                               pixels_checked,
    output logic [15:0]                      column_now,
    output logic [15:0]                      line_now,
    output logic                             image_done_now
);

    logic [7:0]  red_map   [rpu_pkg::MAP_ENTRIES_DEF];
    logic [7:0]  green_map [rpu_pkg::MAP_ENTRIES_DEF];
    logic [7:0]  blue_map  [rpu_pkg::MAP_ENTRIES_DEF];

    logic [15:0] cur_width;
    logic [15:0] cur_height;
    logic [1:0]  cur_depth;
    logic        cur_red_first;
    logic        cur_use_map;

    logic [1:0]  byte_pos;
    logic [15:0] held_pair;
    logic [15:0] col_count;
    logic [15:0] line_num;
    logic        skip_pad;
    logic        frame_done;

    rpu_pkg::pix_t pixel_fifo [$];
    int            errors = 0;
    int            checked = 0;

    initial begin
        foreach (red_map[i]) begin
            red_map[i]   = '0;
            green_map[i] = '0;
            blue_map[i]  = '0;
        end
    end

    task automatic apply_reg(input logic [rpu_pkg::CFG_INDEX_W-1:0] which,
                             input logic [rpu_pkg::CFG_DATA_W-1:0] value);
        case (which)
            rpu_pkg::CFG_IMAGE_WIDTH:   cur_width     = value;
            rpu_pkg::CFG_IMAGE_HEIGHT:  cur_height    = value;
            rpu_pkg::CFG_DEPTH_MODE:    cur_depth     = value[1:0];
            rpu_pkg::CFG_RED_FIRST:     cur_red_first = value[0];
            rpu_pkg::CFG_USE_COLOR_MAP: cur_use_map   = value[0];
            default: ;
        endcase
    endtask

    task automatic decode_beat(input logic cmd, input logic [1:0] plane,
                               input logic [7:0] idx, input logic [7:0] data);
        logic [1:0]    final_pos;
        logic          known_depth;
        rpu_pkg::pix_t px;
        known_depth = 1'b1;
        final_pos   = 2'd0;
        case (cur_depth)
            rpu_pkg::DEPTH_8:  final_pos = 2'd0;
            rpu_pkg::DEPTH_24: final_pos = 2'd2;
            rpu_pkg::DEPTH_32: final_pos = 2'd3;
            default:           known_depth = 1'b0;
        endcase
        if (cmd == rpu_pkg::CMD_MAP_WRITE) begin
            case (plane)
                rpu_pkg::PLANE_RED:   red_map[idx]   = data;
                rpu_pkg::PLANE_GREEN: green_map[idx] = data;
                rpu_pkg::PLANE_BLUE:  blue_map[idx]  = data;
                default: ;
            endcase
        end else if (frame_done || !known_depth) begin
            // raster bytes after the image or in the unused depth vanish
        end else if (skip_pad) begin
            skip_pad = 1'b0;
        end else if (byte_pos < final_pos) begin
            if (cur_depth == rpu_pkg::DEPTH_32 && byte_pos == 2'd0) begin
                // leading pad byte of a 32-bit pixel
            end else if ((cur_depth == rpu_pkg::DEPTH_24 && byte_pos == 2'd0) ||
                         (cur_depth == rpu_pkg::DEPTH_32 && byte_pos == 2'd1)) begin
                held_pair[7:0] = data;
            end else begin
                held_pair[15:8] = data;
            end
            byte_pos = byte_pos + 2'd1;
        end else begin
            byte_pos = 2'd0;
            if (cur_depth == rpu_pkg::DEPTH_8) begin
                px.red   = data;
                px.green = data;
                px.blue  = data;
            end else if (cur_red_first) begin
                px.red   = held_pair[7:0];
                px.green = held_pair[15:8];
                px.blue  = data;
            end else begin
                px.blue  = held_pair[7:0];
                px.green = held_pair[15:8];
                px.red   = data;
            end
            if (cur_use_map) begin
                px.red   = red_map[px.red];
                px.green = green_map[px.green];
                px.blue  = blue_map[px.blue];
            end
            px.column     = col_count;
            px.row        = cur_height - 16'd1 - line_num;
            px.last_pixel = 1'b0;
            col_count = col_count + 16'd1;
            if (col_count == cur_width) begin
                col_count = '0;
                if (cur_depth != rpu_pkg::DEPTH_32 && cur_width[0])
                    skip_pad = 1'b1;
                line_num = line_num + 16'd1;
                if (line_num == cur_height) begin
                    frame_done    = 1'b1;
                    skip_pad      = 1'b0;
                    px.last_pixel = 1'b1;
                end
            end
            pixel_fifo.push_back(px);
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    task automatic check_pixel();
        rpu_pkg::pix_t want;
        if (pixel_fifo.size() == 0) begin
            errors++;
            $display("%0t: pixel with nothing expected: expected none, got column %0d row %0d",
                     $time, m_column, m_row);
        end else begin
            want = pixel_fifo.pop_front();
            checked++;
            check_field("red",        16'(want.red),        16'(m_red));
            check_field("green",      16'(want.green),      16'(m_green));
            check_field("blue",       16'(want.blue),       16'(m_blue));
            check_field("column",     want.column,          m_column);
            check_field("row",        want.row,             m_row);
            check_field("last_pixel", 16'(want.last_pixel), 16'(m_last_pixel));
        end
    endtask

    // A register written at an edge only governs beats from the next edge on,
    // so decode the beat of this edge before applying the write.
    always @(posedge aclk) begin
        if (!aresetn) begin
            cur_width     = 16'd1;
            cur_height    = 16'd1;
            cur_depth     = rpu_pkg::DEPTH_8;
            cur_red_first = 1'b0;
            cur_use_map   = 1'b0;
            byte_pos      = '0;
            held_pair     = '0;
            col_count     = '0;
            line_num      = '0;
            skip_pad      = 1'b0;
            frame_done    = 1'b0;
            pixel_fifo.delete();
        end else begin
            if (s_valid && s_ready)
                decode_beat(s_command, s_map_plane, s_map_index, s_data_byte);
            if (cfg_we)
                apply_reg(cfg_index, cfg_wdata);
            if (m_valid && m_ready)
                check_pixel();
        end
        error_count    <= errors;
        pending        <= pixel_fifo.size();
        pixels_checked <= checked;
        column_now     <= col_count;
        line_now       <= line_num;
        image_done_now <= frame_done;
    end

endmodule

// ===== sim/testbench.sv =====
// Stimulus, output back-pressure, watchdog and verdict for the raster pixel unpacker.
`timescale 1ns / 100ps
module testbench;

    localparam int         WATCHDOG_LIMIT = 2000;
    localparam int         HOLD_CYCLES    = 80;
    localparam int         RANDOM_BEATS   = 1100;
    localparam int         LINE_MARGIN    = 200;
    // codes the block must still tolerate: a plane outside the package enum and the unused depth
    localparam logic [1:0] PLANE_UNUSED   = 2'd3;
    localparam logic [1:0] DEPTH_UNUSED   = 2'd3;

    // every block input starts at a known value
    logic                            aclk        = 1'b0;
    logic                            aresetn     = 1'b0;
    logic                            cfg_we      = 1'b0;
    logic [rpu_pkg::CFG_INDEX_W-1:0] cfg_index   = '0;
    logic [rpu_pkg::CFG_DATA_W-1:0]  cfg_wdata   = '0;
    logic                            s_valid     = 1'b0;
    logic                            s_command   = 1'b0;
    logic [1:0]                      s_map_plane = '0;
    logic [7:0]                      s_map_index = '0;
    logic [7:0]                      s_data_byte = '0;
    logic                            m_ready     = 1'b0;

    logic                   s_ready;
    logic                   m_valid;
    logic [7:0]             m_red;
    logic [7:0]             m_green;
    logic [7:0]             m_blue;
    logic [15:0]            m_column;
    logic [15:0]            m_row;
    logic                   m_last_pixel;

    // predictor view handed up by the checker
    int                     error_count;
    int                     pending;
    int                     pixels_checked;
    logic [15:0]            column_now;
    logic [15:0]            line_now;
    logic                   image_done_now;

    bit                     tx_gaps     = 1'b0;
    bit                     rx_stalls   = 1'b0;
    int                     hold_req    = 0;
    int                     hold_served = 0;
    int                     idle_cycles = 0;
    int                     beats_sent  = 0;
    int                     settings_used = 0;

    always #1 aclk = ~aclk;

    raster_pixel_unpacker DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_command    (s_command),
        .s_map_plane  (s_map_plane),
        .s_map_index  (s_map_index),
        .s_data_byte  (s_data_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_red        (m_red),
        .m_green      (m_green),
        .m_blue       (m_blue),
        .m_column     (m_column),
        .m_row        (m_row),
        .m_last_pixel (m_last_pixel)
    );

    unpacker_checker pixel_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_command      (s_command),
        .s_map_plane    (s_map_plane),
        .s_map_index    (s_map_index),
        .s_data_byte    (s_data_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_red          (m_red),
        .m_green        (m_green),
        .m_blue         (m_blue),
        .m_column       (m_column),
        .m_row          (m_row),
        .m_last_pixel   (m_last_pixel),
        .error_count    (error_count),
        .pending        (pending),
        .pixels_checked (pixels_checked),
        .column_now     (column_now),
        .line_now       (line_now),
        .image_done_now (image_done_now)
    );

    // Offer one input beat and hold it until the block takes it. Valid is only
    // dropped when a gap is drawn, so back-to-back beats keep it high.
    task automatic send_beat(input rpu_pkg::cmd_t cmd, input logic [1:0] plane,
                             input logic [7:0] idx, input logic [7:0] data);
        int gap;
        gap = tx_gaps ? $urandom_range(0, 9) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_command   <= cmd;
        s_map_plane <= plane;
        s_map_index <= idx;
        s_data_byte <= data;
        do @(posedge aclk); while (!s_ready);
        beats_sent++;
    endtask

    // Raster beats carry random plane and index bits, which the block must ignore.
    task automatic raster(input logic [7:0] data);
        send_beat(rpu_pkg::CMD_RASTER, 2'($urandom_range(0, 3)), 8'($urandom), data);
    endtask

    task automatic map_write(input logic [1:0] plane, input logic [7:0] idx,
                             input logic [7:0] data);
        send_beat(rpu_pkg::CMD_MAP_WRITE, plane, idx, data);
    endtask

    task automatic write_reg(input rpu_pkg::cfg_index_t which,
                             input logic [rpu_pkg::CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= which;
        cfg_wdata <= value;
        @(posedge aclk);
    endtask

    // Write every register back to back; call only while the block is idle.
    task automatic load_settings(input logic [15:0] width, input logic [15:0] height,
                                 input logic [1:0] depth, input logic red_first,
                                 input logic use_map);
        write_reg(rpu_pkg::CFG_IMAGE_WIDTH,   width);
        write_reg(rpu_pkg::CFG_IMAGE_HEIGHT,  height);
        write_reg(rpu_pkg::CFG_DEPTH_MODE,    16'(depth));
        write_reg(rpu_pkg::CFG_RED_FIRST,     16'(red_first));
        write_reg(rpu_pkg::CFG_USE_COLOR_MAP, 16'(use_map));
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    // Drop valid, wait until every predicted pixel has left, then let the
    // two-stage pipeline run on in case a byte without a pixel
    // is still in flight.
    task automatic settle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (6) @(posedge aclk);
    endtask

    // Keep the width above the running column so lines end without a wrap.
    function automatic logic [15:0] pick_width();
        int c;
        int roll;
        c    = column_now;
        roll = $urandom_range(0, 9);
        if (roll < 7)
            pick_width = 16'(c + 1 + $urandom_range(0, 6));
        else if (roll < 9)
            pick_width = 16'(c + 1 + $urandom_range(0, 65534 - c));
        else
            pick_width = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    endfunction

    // Steer the height clear of the next 200 lines so the image
    // cannot end before the final phase; a zero height stands for 65536.
    function automatic logic [15:0] pick_height();
        int ln;
        int h;
        int roll;
        ln = line_now;
        do begin
            roll = $urandom_range(0, 9);
            if (roll < 7)
                h = $urandom_range(0, 65535);
            else if (roll == 7)
                h = 1;
            else if (roll == 8)
                h = 65535;
            else
                h = 0;
            if (h == 0)
                h = 65536;
        end while (h > ln && h <= ln + LINE_MARGIN);
        pick_height = 16'(h);
    endfunction

    // Result side: per pixel draw a stall while rx_stalls is set, or serve a long hold-off
    // when the stimulus asks for one so the pipeline fills and s_ready drops.
    initial begin : result_sink
        int n;
        forever begin
            if (hold_req != hold_served) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_served++;
            end else if (rx_stalls) begin
                n = $urandom_range(0, 9);
                if (n > 0) begin
                    m_ready <= 1'b0;
                    repeat (n) @(posedge aclk);
                end
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // Watchdog: end the run if neither channel moves a beat for too long.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles == WATCHDOG_LIMIT) begin
                $display("%0t: no beat accepted for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial begin : stimulus
        rpu_pkg::plane_t fill_planes [3];
        int              n;
        int              mode;
        int              phase;
        int              random_sent;
        logic [1:0]      depth;
        fill_planes = '{rpu_pkg::PLANE_RED, rpu_pkg::PLANE_GREEN, rpu_pkg::PLANE_BLUE};
        phase       = 0;
        random_sent = 0;

        // hold reset, then release it for good
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Load every entry of all three planes before any lookup can happen.
        tx_gaps   = 1'b1;
        rx_stalls = 1'b1;
        for (int p = 0; p < 3; p++)
            for (int i = 0; i < rpu_pkg::MAP_ENTRIES_DEF; i++)
                map_write(fill_planes[p], 8'(i), 8'($urandom));

        // Directed: 8-bit gray extremes on an odd line with its pad byte.
        settle();
        tx_gaps   = 1'b0;
        rx_stalls = 1'b0;
        load_settings(16'd3, 16'hFFFF, rpu_pkg::DEPTH_8, 1'b0, 1'b0);
        raster(8'h00);
        raster(8'hFF);
        raster(8'hA5);
        raster(8'h5A);

        // 8-bit through the map; a write to the unused plane must change nothing.
        settle();
        load_settings(16'd3, 16'hFFFF, rpu_pkg::DEPTH_8, 1'b0, 1'b1);
        map_write(PLANE_UNUSED, 8'h00, 8'h77);
        raster(8'h00);
        raster(8'hFF);
        raster(8'h80);
        raster(8'h33);

        // 24-bit in both channel orders, one pixel per line plus a pad byte.
        settle();
        load_settings(16'd1, 16'hFFFF, rpu_pkg::DEPTH_24, 1'b0, 1'b0);
        raster(8'h11);
        raster(8'h22);
        raster(8'h33);
        raster(8'hEE);
        settle();
        load_settings(16'd1, 16'hFFFF, rpu_pkg::DEPTH_24, 1'b1, 1'b0);
        raster(8'h44);
        raster(8'h55);
        raster(8'h66);
        raster(8'hEE);

        // 32-bit with the map: drop the leading byte, no line padding.
        settle();
        load_settings(16'd2, 16'hFFFF, rpu_pkg::DEPTH_32, 1'b1, 1'b1);
        raster(8'h00);
        raster(8'hC3);
        raster(8'h3C);
        raster(8'h99);
        // stop mid-pixel, switch to 8-bit, and let the next byte finish it
        raster(8'hAA);
        raster(8'hBB);
        settle();
        load_settings(16'd2, 16'hFFFF, rpu_pkg::DEPTH_8, 1'b0, 1'b0);
        raster(8'hCC);

        // unused depth drops raster bytes; then zero width and height count as 65536
        settle();
        load_settings(16'd4, 16'h0000, DEPTH_UNUSED, 1'b0, 1'b0);
        raster(8'h01);
        settle();
        load_settings(16'h0000, 16'h0000, rpu_pkg::DEPTH_24, 1'b0, 1'b1);
        raster(8'h0F);
        raster(8'hF0);
        raster(8'h5A);

        // Random phases: fresh settings each time, mostly raster bytes with
        // some map writes mixed in, idling varied from phase to phase.
        while (random_sent < RANDOM_BEATS) begin
            settle();
            mode      = phase % 4;
            tx_gaps   = (mode == 1 || mode == 3);
            rx_stalls = (mode == 2 || mode == 3);
            depth     = 2'($urandom_range(0, 2));
            n         = $urandom_range(20, 80);
            if (phase == 2) begin
                // burst 8-bit pixels into a stalled output
                tx_gaps = 1'b0;
                depth   = rpu_pkg::DEPTH_8;
                n       = 60;
            end
            load_settings(pick_width(), pick_height(), depth,
                          1'($urandom), 1'($urandom));
            if (phase == 2)
                hold_req++;
            repeat (n) begin
                if ($urandom_range(0, 7) == 0)
                    map_write(2'($urandom_range(0, 3)), 8'($urandom), 8'($urandom));
                else
                    raster(8'($urandom));
            end
            random_sent += n;
            phase++;
        end

        // Finish the image: end the current line and one more, so the last
        // pixel lands on row 0. Raster bytes after it must vanish.
        settle();
        tx_gaps   = 1'b1;
        rx_stalls = 1'b1;
        load_settings(column_now + 16'd2, line_now + 16'd2, 2'($urandom_range(0, 2)),
                      1'($urandom), 1'($urandom));
        while (!image_done_now)
            raster(8'($urandom));
        raster(8'($urandom));
        raster(8'($urandom));
        map_write(rpu_pkg::PLANE_GREEN, 8'($urandom), 8'($urandom));

        settle();
        repeat (10) @(posedge aclk);
        $display("Run covered %0d input beats under %0d register settings, %0d pixels checked.",
                 beats_sent, settings_used, pixels_checked);
        $display("Depths 8/24/32, map on and off, both orders, pads, hold-off, last pixel.");
        if (error_count == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/rpu_pkg.sv
rtl/rpu_ram.sv
rtl/rpu_decode.sv
rtl/raster_pixel_unpacker.sv
sim/unpacker_checker.sv
sim/testbench.sv
